// ===== rtl/pps_pkg.sv =====
// Package for the preemptive priority scheduler: sizes, slot record,
// controller/datapath command and status types. No dependencies.
`default_nettype none

package pps_pkg;

    localparam int MAX_JOBS  = 16;
    localparam int TIME_BITS = 16;

    localparam int IDX_BITS  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_JOBS + 1);
    localparam int WIDE_BITS = (TIME_BITS > 16) ? TIME_BITS : 16;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [WIDE_BITS-1:0] wide_t;

    typedef struct packed {
        logic [3:0]  id;
        logic [15:0] arrival;
        logic [7:0]  prio;
        logic [15:0] remaining;
        logic [15:0] burst;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

    typedef struct packed {
        logic tick_start;
        logic issue;
        logic add_commit;
        logic tick_commit;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/pps_in_if.sv =====
// Input channel of the scheduler: valid/ready plus job or tick payload.
// Depends on nothing.
`default_nettype none

interface pps_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [3:0]  job_id;
    logic [15:0] arrival_time;
    logic [7:0]  prio_level;
    logic [15:0] burst_length;

    modport source (output valid, mode, job_id, arrival_time, prio_level, burst_length,
                    input ready);
    modport sink   (input valid, mode, job_id, arrival_time, prio_level, burst_length,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pps_out_if.sv =====
// Result channel of the scheduler: valid/ready plus result payload.
// Depends on nothing.
`default_nettype none

interface pps_out_if;
    logic        valid;
    logic        ready;
    logic        add_accepted;
    logic        ran_job;
    logic [3:0]  running_id;
    logic        job_done;
    logic [15:0] finish_time;
    logic [15:0] turnaround;
    logic [15:0] wait_time;

    modport source (output valid, add_accepted, ran_job, running_id, job_done,
                    finish_time, turnaround, wait_time, input ready);
    modport sink   (input valid, add_accepted, ran_job, running_id, job_done,
                    finish_time, turnaround, wait_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/pps_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/pps_ctrl.sv =====
// Scheduler controller: accepts transactions, sequences the slot scan and commit.
// Depends on pps_pkg.
`default_nettype none

module pps_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_mode,
    output logic                  in_ready,
    input  wire pps_pkg::status_t status,
    output pps_pkg::cmd_t         cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) && status.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.add_commit  = accept && (in_mode == pps_pkg::MODE_ADD);
        cmd.tick_start  = accept && (in_mode == pps_pkg::MODE_TICK);
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.tick_start)
                begin
                    state_next = status.count_zero ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.tick_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> $past(state_reg) == S_SCAN)
        else $error("drain not entered from scan");

    a_issue_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !cmd.add_commit && !cmd.tick_commit && !in_ready)
        else $error("scan overlaps commit or accept");

    a_commit_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_commit |-> state_reg == S_DECIDE)
        else $error("tick commit outside decide");

endmodule

`default_nettype wire

// ===== rtl/pps_dpath.sv =====
// Scheduler datapath: slot RAM, fill count, time, best-slot compare, result register.
// Depends on pps_pkg and pps_ram.
`default_nettype none

module pps_dpath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pps_pkg::cmd_t    cmd,
    output pps_pkg::status_t      status,
    input  wire logic [3:0]       job_id,
    input  wire logic [15:0]      arrival_time,
    input  wire logic [7:0]       prio_level,
    input  wire logic [15:0]      burst_length,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  add_accepted,
    output logic                  ran_job,
    output logic [3:0]            running_id,
    output logic                  job_done,
    output logic [15:0]           finish_time,
    output logic [15:0]           turnaround,
    output logic [15:0]           wait_time
);

    pps_pkg::cnt_t  count_reg;
    pps_pkg::time_t now_reg;
    pps_pkg::idx_t  scan_reg;
    logic           rd_pend_reg;
    pps_pkg::idx_t  rd_idx_reg;

    logic           best_found_reg;
    pps_pkg::idx_t  best_idx_reg;
    pps_pkg::slot_t best_reg;

    logic           out_valid_reg;
    logic           add_accepted_reg;
    logic           ran_job_reg;
    logic [3:0]     running_id_reg;
    logic           job_done_reg;
    logic [15:0]    finish_time_reg;
    logic [15:0]    turnaround_reg;
    logic [15:0]    wait_time_reg;

    logic                           ram_we;
    pps_pkg::idx_t                  ram_waddr;
    logic [pps_pkg::SLOT_BITS-1:0]  ram_wdata;
    logic [pps_pkg::SLOT_BITS-1:0]  ram_rdata;
    pps_pkg::slot_t                 rd_slot;
    pps_pkg::slot_t                 new_slot;
    pps_pkg::slot_t                 upd_slot;

    logic           full;
    logic           cand_ready;
    logic           cand_better;
    pps_pkg::time_t now_inc;
    logic [15:0]    rem_dec;
    logic           done;
    pps_pkg::wide_t fin_w;
    pps_pkg::wide_t tat_w;
    pps_pkg::wide_t wt_w;

    assign full    = (count_reg == pps_pkg::cnt_t'(pps_pkg::MAX_JOBS));
    assign rd_slot = pps_pkg::slot_t'(ram_rdata);

    assign status.count_zero = (count_reg == '0);
    assign status.scan_last  = (pps_pkg::cnt_t'(scan_reg) + pps_pkg::cnt_t'(1)) == count_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign cand_ready = (rd_slot.remaining != '0) &&
                        (pps_pkg::wide_t'(rd_slot.arrival) <= pps_pkg::wide_t'(now_reg));
    assign cand_better = !best_found_reg ||
                         (rd_slot.prio < best_reg.prio) ||
                         ((rd_slot.prio == best_reg.prio) &&
                          (rd_slot.arrival < best_reg.arrival));

    assign now_inc = (&now_reg) ? now_reg : now_reg + pps_pkg::time_t'(1);
    assign rem_dec = best_reg.remaining - 16'd1;
    assign done    = best_found_reg && (rem_dec == '0);
    assign fin_w   = pps_pkg::wide_t'(now_inc);
    assign tat_w   = fin_w - pps_pkg::wide_t'(best_reg.arrival);
    assign wt_w    = (tat_w >= pps_pkg::wide_t'(best_reg.burst)) ?
                     tat_w - pps_pkg::wide_t'(best_reg.burst) : '0;

    always_comb
    begin
        new_slot.id        = job_id;
        new_slot.arrival   = arrival_time;
        new_slot.prio      = prio_level;
        new_slot.remaining = burst_length;
        new_slot.burst     = burst_length;
        upd_slot           = best_reg;
        upd_slot.remaining = rem_dec;
        if (cmd.add_commit)
        begin
            ram_we    = !full;
            ram_waddr = count_reg[pps_pkg::IDX_BITS-1:0];
            ram_wdata = new_slot;
        end
        else
        begin
            ram_we    = cmd.tick_commit && best_found_reg;
            ram_waddr = best_idx_reg;
            ram_wdata = upd_slot;
        end
    end

    pps_ram #(
        .WIDTH (pps_pkg::SLOT_BITS),
        .DEPTH (pps_pkg::MAX_JOBS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            now_reg        <= '0;
            scan_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.issue;
            if (cmd.add_commit && !full)
            begin
                count_reg <= count_reg + pps_pkg::cnt_t'(1);
            end
            if (cmd.tick_commit)
            begin
                now_reg <= now_inc;
            end
            if (cmd.tick_start)
            begin
                scan_reg       <= '0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    scan_reg <= scan_reg + pps_pkg::idx_t'(1);
                end
                if (rd_pend_reg && cand_ready && cand_better)
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.add_commit || cmd.tick_commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_reg;
        if (rd_pend_reg && cand_ready && cand_better && !cmd.tick_start)
        begin
            best_idx_reg <= rd_idx_reg;
            best_reg     <= rd_slot;
        end
        if (cmd.add_commit)
        begin
            add_accepted_reg <= !full;
            ran_job_reg      <= 1'b0;
            running_id_reg   <= '0;
            job_done_reg     <= 1'b0;
            finish_time_reg  <= '0;
            turnaround_reg   <= '0;
            wait_time_reg    <= '0;
        end
        else if (cmd.tick_commit)
        begin
            add_accepted_reg <= 1'b0;
            ran_job_reg      <= best_found_reg;
            running_id_reg   <= best_found_reg ? best_reg.id : 4'd0;
            job_done_reg     <= done;
            finish_time_reg  <= done ? fin_w[15:0] : 16'd0;
            turnaround_reg   <= done ? tat_w[15:0] : 16'd0;
            wait_time_reg    <= done ? wt_w[15:0] : 16'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign add_accepted = add_accepted_reg;
    assign ran_job      = ran_job_reg;
    assign running_id   = running_id_reg;
    assign job_done     = job_done_reg;
    assign finish_time  = finish_time_reg;
    assign turnaround   = turnaround_reg;
    assign wait_time    = wait_time_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pps_pkg::cnt_t'(pps_pkg::MAX_JOBS))
        else $error("job count beyond table size");

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> now_reg >= $past(now_reg))
        else $error("time went backward");

    a_done_implies_ran: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && job_done_reg |-> ran_job_reg && !add_accepted_reg)
        else $error("completion without a running job");

endmodule

`default_nettype wire

// ===== rtl/preemptive_priority_scheduler_top.sv =====
// Top level of the preemptive priority scheduler: controller plus datapath.
// Depends on pps_pkg, pps_in_if, pps_out_if, pps_ctrl, pps_dpath.
//
//   channel  dir  transaction
//   in_ch    in   add job (mode 0) or scheduling tick (mode 1)
//   out_ch   out  one result per input transaction
//
// Add: result registered at the accepting edge.
// Tick: scan, drain and decide states; the scan reads the slot RAM one slot per cycle
// through its single registered read port. An empty table goes straight to decide.
// Reset clears job count, time and handshake state; slot RAM is not cleared.
// A result held in the output register stalls the input; a scan never stalls.
`default_nettype none

module preemptive_priority_scheduler_top (
    input  wire logic clk,
    input  wire logic rst_n,
    pps_in_if.sink    in_ch,
    pps_out_if.source out_ch
);

    pps_pkg::cmd_t    cmd;
    pps_pkg::status_t status;

    pps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_mode  (in_ch.mode),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pps_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .job_id       (in_ch.job_id),
        .arrival_time (in_ch.arrival_time),
        .prio_level   (in_ch.prio_level),
        .burst_length (in_ch.burst_length),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .add_accepted (out_ch.add_accepted),
        .ran_job      (out_ch.ran_job),
        .running_id   (out_ch.running_id),
        .job_done     (out_ch.job_done),
        .finish_time  (out_ch.finish_time),
        .turnaround   (out_ch.turnaround),
        .wait_time    (out_ch.wait_time)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for preemptive_priority_scheduler_top: drives add and tick
// transactions, predicts every result, compares them field by field on the result channel.
// Depends on pps_pkg, pps_in_if, pps_out_if and the scheduler RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int TIME_TOP    = (1 << pps_pkg::TIME_BITS) - 1;

    typedef struct packed {
        logic           mode;
        logic [3:0]     job_id;
        pps_pkg::time_t arrival;
        logic [7:0]     prio;
        pps_pkg::time_t burst;
    } job_req_t;

    typedef struct packed {
        logic           add_accepted;
        logic           ran_job;
        logic [3:0]     running_id;
        logic           job_done;
        pps_pkg::time_t finish_time;
        pps_pkg::time_t turnaround;
        pps_pkg::time_t wait_time;
    } sched_result_t;

    logic clk;
    logic rst_n;

    pps_in_if  in_ch();
    pps_out_if out_ch();

    preemptive_priority_scheduler_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // scheduler image
    logic           job_present [pps_pkg::MAX_JOBS] = '{default: 1'b0};
    logic [3:0]     job_ids     [pps_pkg::MAX_JOBS];
    pps_pkg::time_t job_arrival [pps_pkg::MAX_JOBS];
    logic [7:0]     job_prio    [pps_pkg::MAX_JOBS];
    pps_pkg::time_t job_left    [pps_pkg::MAX_JOBS];
    pps_pkg::time_t job_burst   [pps_pkg::MAX_JOBS];
    int unsigned    jobs_stored = 0;
    pps_pkg::time_t sched_now   = '0;

    job_req_t      pending_reqs [$];
    sched_result_t expected_results [$];
    job_req_t      offered_req;
    sched_result_t got_result;
    sched_result_t want_result;

    int unsigned ticks_queued = 0;
    int unsigned send_odds    = 0;
    int unsigned recv_odds    = 0;
    int unsigned send_gap     = 0;
    int unsigned recv_gap     = 0;
    int unsigned hold_left    = 0;
    int unsigned results_seen = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches   = 0;

    function automatic sched_result_t schedule_step(job_req_t req);
        sched_result_t  r;
        int             pick;
        pps_pkg::time_t tat;
        r    = '0;
        pick = -1;
        if (req.mode == pps_pkg::MODE_ADD)
        begin
            if (jobs_stored < pps_pkg::MAX_JOBS)
            begin
                job_present[jobs_stored] = 1'b1;
                job_ids[jobs_stored]     = req.job_id;
                job_arrival[jobs_stored] = req.arrival;
                job_prio[jobs_stored]    = req.prio;
                job_left[jobs_stored]    = req.burst;
                job_burst[jobs_stored]   = req.burst;
                jobs_stored++;
                r.add_accepted = 1'b1;
            end
            return r;
        end
        for (int k = 0; k < pps_pkg::MAX_JOBS; k++)
        begin
            if (job_present[k] && job_left[k] != '0 && job_arrival[k] <= sched_now)
            begin
                if (pick < 0 || job_prio[k] < job_prio[pick] ||
                    (job_prio[k] == job_prio[pick] && job_arrival[k] < job_arrival[pick]))
                    pick = k;
            end
        end
        if (sched_now != pps_pkg::time_t'(TIME_TOP))
            sched_now = sched_now + 1'b1;
        if (pick >= 0)
        begin
            r.ran_job      = 1'b1;
            r.running_id   = job_ids[pick];
            job_left[pick] = job_left[pick] - 1'b1;
            if (job_left[pick] == '0)
            begin
                tat           = sched_now - job_arrival[pick];
                r.job_done    = 1'b1;
                r.finish_time = sched_now;
                r.turnaround  = tat;
                r.wait_time   = (tat >= job_burst[pick]) ? tat - job_burst[pick] : '0;
            end
        end
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    task automatic queue_job(int unsigned id, int unsigned arrival, int unsigned prio,
                             int unsigned burst);
        job_req_t req;
        req.mode    = pps_pkg::MODE_ADD;
        req.job_id  = 4'(id);
        req.arrival = pps_pkg::time_t'(arrival);
        req.prio    = 8'(prio);
        req.burst   = pps_pkg::time_t'(burst);
        pending_reqs.insert(pending_reqs.size(), req);
    endtask

    task automatic queue_tick(int unsigned count);
        job_req_t req;
        for (int n = 0; n < count; n++)
        begin
            req.mode    = pps_pkg::MODE_TICK;
            req.job_id  = 4'($urandom);
            req.arrival = pps_pkg::time_t'($urandom);
            req.prio    = 8'($urandom);
            req.burst   = pps_pkg::time_t'($urandom);
            pending_reqs.insert(pending_reqs.size(), req);
            ticks_queued++;
        end
    endtask

    task automatic drain_results();
        while (pending_reqs.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.mode         <= pps_pkg::MODE_ADD;
            in_ch.job_id       <= '0;
            in_ch.arrival_time <= '0;
            in_ch.prio_level   <= '0;
            in_ch.burst_length <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_results.insert(expected_results.size(), schedule_step(offered_req));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    in_ch.valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_reqs.size() != 0)
                begin
                    offered_req = pending_reqs.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.mode         <= offered_req.mode;
                    in_ch.job_id       <= offered_req.job_id;
                    in_ch.arrival_time <= offered_req.arrival;
                    in_ch.prio_level   <= offered_req.prio;
                    in_ch.burst_length <= offered_req.burst;
                    if (send_odds != 0 && $urandom_range(1, send_odds) == 1)
                        send_gap = $urandom_range(1, 15);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                got_result.add_accepted = out_ch.add_accepted;
                got_result.ran_job      = out_ch.ran_job;
                got_result.running_id   = out_ch.running_id;
                got_result.job_done     = out_ch.job_done;
                got_result.finish_time  = out_ch.finish_time;
                got_result.turnaround   = out_ch.turnaround;
                got_result.wait_time    = out_ch.wait_time;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no input transaction outstanding");
                    mismatches++;
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    check_field("add_accepted", 32'(want_result.add_accepted),
                                32'(got_result.add_accepted));
                    check_field("ran_job", 32'(want_result.ran_job),
                                32'(got_result.ran_job));
                    check_field("running_id", 32'(want_result.running_id),
                                32'(got_result.running_id));
                    check_field("job_done", 32'(want_result.job_done),
                                32'(got_result.job_done));
                    check_field("finish_time", 32'(want_result.finish_time),
                                32'(got_result.finish_time));
                    check_field("turnaround", 32'(want_result.turnaround),
                                32'(got_result.turnaround));
                    check_field("wait_time", 32'(want_result.wait_time),
                                32'(got_result.wait_time));
                end
                // long back-pressure so the block fills and stalls its input
                if (results_seen == 300 || results_seen == 1000)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (recv_gap != 0)
            begin
                out_ch.ready <= 1'b0;
                recv_gap--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1)
                    recv_gap = $urandom_range(1, 15);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned id;
        int unsigned arrival;
        int unsigned prio;
        int unsigned burst;
        in_ch.valid        = 1'b0;
        in_ch.mode         = pps_pkg::MODE_ADD;
        in_ch.job_id       = '0;
        in_ch.arrival_time = '0;
        in_ch.prio_level   = '0;
        in_ch.burst_length = '0;
        out_ch.ready       = 1'b0;
        rst_n              = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        queue_tick(1);                      // empty table: idle tick
        queue_job(0, 0, 255, 1);            // same prio and arrival as next: lower slot wins
        queue_job(15, 0, 255, 2);
        queue_job(3, 3, 0, 2);              // arrives later and preempts
        queue_job(7, 1, 255, 1);            // prio tie, later arrival loses
        queue_job(9, 2, 10, 0);             // zero burst, never ready
        queue_job(5, 65530, 0, 30);         // far arrival, stays waiting
        queue_job(10, 65535, 0, 1);         // arrival at the last time value
        queue_job(12, 40000, 128, 65535);   // longest burst
        queue_tick(11);
        drain_results();

        // random, idling changes every chunk
        for (int chunk = 0; chunk < 14; chunk++)
        begin
            send_odds = 4 * $urandom_range(0, 3);
            recv_odds = 4 * $urandom_range(0, 3);
            for (int n = 0; n < 100; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    id = $urandom_range(0, 15);
                    prio = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: arrival = ticks_queued + $urandom_range(0, 30);
                        4, 5, 6:    arrival = ticks_queued + $urandom_range(0, 1500);
                        7:          arrival = ticks_queued & ~32'd7;
                        default:    arrival = $urandom_range(0, TIME_TOP);
                    endcase
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: burst = $urandom_range(1, 20);
                        6, 7, 8:          burst = $urandom_range(1, 400);
                        default:          burst = $urandom_range(0, TIME_TOP);
                    endcase
                    queue_job(id, arrival, prio, burst);
                end
                else
                    queue_tick(1);
            end
            while (pending_reqs.size() > 4)
                @(negedge clk);
        end
        drain_results();

        // last stretch, no idling
        send_odds = 0;
        recv_odds = 0;
        queue_tick(100);
        drain_results();
        repeat (64) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
